// ----- hdl/pcf_pkg.sv -----
// pcf_pkg: shared types, constants and fixed-point helpers of the pitch fusion block
// used by pcf_div, pcf_dp, pcf_ctrl and the top level; no dependencies
package pcf_pkg;

   // field and state widths
   localparam int AngW   = 25;
   localparam int RateW  = 28;
   localparam int DtW    = 16;
   localparam int AlphaW = 17;
   localparam int NoiseW = 32;
   localparam int CovW   = 40;
   localparam int GainW  = 32;
   localparam int SumW   = 42;   // innovation variance
   localparam int TbW    = 41;   // rounded dt * cov_bb
   localparam int PredW  = 30;
   localparam int YW     = 26;
   // dt / alpha multiplier
   localparam int M1aW   = 44;
   localparam int M1bW   = 18;
   localparam int M1pW   = M1aW + M1bW;
   // gain multiplier
   localparam int M2bW   = 27;
   localparam int M2pW   = GainW + M2bW;
   localparam int IdxW   = 5;
   localparam int AddrW  = 5;

   localparam logic signed [63:0] AngMax  = 64'sd11796480;
   localparam logic signed [63:0] BiasMax = 64'sd131072000;
   localparam logic signed [63:0] CovMax  = 64'sd549755813887;
   localparam logic signed [63:0] CovMin  = -64'sd549755813888;
   localparam logic [CovW-1:0]    OneQ24  = 40'd16777216;
   localparam logic [AlphaW-1:0]  AlphaOne = 17'd65536;

   localparam logic [IdxW-1:0] PreLast  = 5'd6;
   localparam logic [IdxW-1:0] PostLast = 5'd16;

   // register indexes
   localparam logic [2:0] REG_TARE   = 3'd0;
   localparam logic [2:0] REG_ALPHA  = 3'd1;
   localparam logic [2:0] REG_ANOISE = 3'd2;
   localparam logic [2:0] REG_BNOISE = 3'd3;
   localparam logic [2:0] REG_MNOISE = 3'd4;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_PRED,
      OP_BA,
      OP_BT,
      OP_ANG,
      OP_TB,
      OP_AA,
      OP_BB,
      OP_K0Y,
      OP_K1Y,
      OP_HI_BA,
      OP_LO_BA,
      OP_HI_BB,
      OP_LO_BB,
      OP_HI_AB,
      OP_LO_AB,
      OP_HI_AA,
      OP_LO_AA
   } op_type;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_PRE  = 5'b00010,
      ST_DIV  = 5'b00100,
      ST_POST = 5'b01000,
      ST_OUT  = 5'b10000
   } state_type;

   typedef struct packed {
      op_type op;
      logic   phase;      // 0: multiply, 1: write back
      logic   load_in;
      logic   div_start;
      logic   load_out;
   } cmd_type;

   // round half up, then arithmetic shift
   function automatic logic signed [63:0] rnd(input logic signed [63:0] v, input int n);
      rnd = (v + (64'sd1 <<< (n - 1))) >>> n;
   endfunction

   function automatic logic signed [63:0] sat(input logic signed [63:0] v,
                                              input logic signed [63:0] lim);
      if (v > lim)
         sat = lim;
      else if (v < -lim)
         sat = -lim;
      else
         sat = v;
   endfunction

   function automatic logic signed [63:0] satcov(input logic signed [63:0] v);
      if (v > CovMax)
         satcov = CovMax;
      else if (v < CovMin)
         satcov = CovMin;
      else
         satcov = v;
   endfunction

   // micro-op sequence of one update
   function automatic op_type op_at(input logic [IdxW-1:0] idx);
      case (idx)
         5'd0:    op_at = OP_PRED;
         5'd1:    op_at = OP_BA;
         5'd2:    op_at = OP_BT;
         5'd3:    op_at = OP_ANG;
         5'd4:    op_at = OP_TB;
         5'd5:    op_at = OP_AA;
         5'd6:    op_at = OP_BB;
         5'd7:    op_at = OP_K0Y;
         5'd8:    op_at = OP_K1Y;
         5'd9:    op_at = OP_HI_BA;
         5'd10:   op_at = OP_LO_BA;
         5'd11:   op_at = OP_HI_BB;
         5'd12:   op_at = OP_LO_BB;
         5'd13:   op_at = OP_HI_AB;
         5'd14:   op_at = OP_LO_AB;
         5'd15:   op_at = OP_HI_AA;
         5'd16:   op_at = OP_LO_AA;
         default: op_at = OP_NONE;
      endcase
   endfunction

endpackage

// ----- hdl/pcf_div.sv -----
// pcf_div: two-lane restoring divider for the Kalman gains, one quotient bit per cycle
// depends on pcf_pkg
module pcf_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [pcf_pkg::SumW-1:0]     s,
   input  logic signed [pcf_pkg::CovW-1:0]     a0,
   input  logic signed [pcf_pkg::CovW-1:0]     a1,
   output logic                                done,
   output logic signed [pcf_pkg::GainW-1:0]    k0,
   output logic signed [pcf_pkg::GainW-1:0]    k1
);
   import pcf_pkg::*;

   localparam int MsW = SumW - 1;

   logic                 busy_ff, busy_in;
   logic [4:0]           cnt_ff, cnt_in;
   logic                 done_ff, done_in;
   logic                 zero_ff, zero_in;
   logic [MsW-1:0]       ms_ff, ms_in;
   logic [MsW-1:0]       rem_ff [2];
   logic [MsW-1:0]       rem_in [2];
   logic [GainW-1:0]     num_ff [2];
   logic [GainW-1:0]     num_in [2];
   logic [GainW-1:0]     q_ff [2];
   logic [GainW-1:0]     q_in [2];
   logic                 neg_ff [2];
   logic                 neg_in [2];
   logic                 ovf_ff [2];
   logic                 ovf_in [2];
   logic signed [GainW-1:0] k_c [2];

   // start loads magnitudes, each step makes one quotient bit per lane
   always_comb begin
      logic [MsW-1:0]     ms_c;
      logic [CovW-1:0]    ma_c;
      logic [MsW:0]       t_c;
      logic signed [CovW-1:0] a_c;
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      zero_in = zero_ff;
      ms_in   = ms_ff;
      ms_c    = s[SumW-1] ? MsW'(-s) : MsW'(s);
      for (int i = 0; i < 2; i++) begin
         rem_in[i] = rem_ff[i];
         num_in[i] = num_ff[i];
         q_in[i]   = q_ff[i];
         neg_in[i] = neg_ff[i];
         ovf_in[i] = ovf_ff[i];
         a_c  = (i == 0) ? a0 : a1;
         ma_c = a_c[CovW-1] ? CovW'(-a_c) : CovW'(a_c);
         t_c  = {rem_ff[i], num_ff[i][GainW-1]};
         if (start) begin
            rem_in[i] = MsW'(ma_c >> 8);
            num_in[i] = {ma_c[7:0], 24'd0};
            q_in[i]   = '0;
            neg_in[i] = a_c[CovW-1] ^ s[SumW-1];
            ovf_in[i] = ({9'd0, ma_c} >= {ms_c, 8'd0});
         end else if (busy_ff) begin
            num_in[i] = {num_ff[i][GainW-2:0], 1'b0};
            if (t_c >= {1'b0, ms_ff}) begin
               rem_in[i] = MsW'(t_c - {1'b0, ms_ff});
               q_in[i]   = {q_ff[i][GainW-2:0], 1'b1};
            end else begin
               rem_in[i] = t_c[MsW-1:0];
               q_in[i]   = {q_ff[i][GainW-2:0], 1'b0};
            end
         end
      end
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 5'd31;
         ms_in   = ms_c;
         zero_in = (s == '0);
      end else if (busy_ff) begin
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      zero_ff <= zero_in;
      ms_ff   <= ms_in;
      for (int i = 0; i < 2; i++) begin
         rem_ff[i] <= rem_in[i];
         num_ff[i] <= num_in[i];
         q_ff[i]   <= q_in[i];
         neg_ff[i] <= neg_in[i];
         ovf_ff[i] <= ovf_in[i];
      end
   end

   // sign and saturation of the quotients
   always_comb begin
      for (int i = 0; i < 2; i++) begin
         if (zero_ff)
            k_c[i] = '0;
         else if (neg_ff[i])
            k_c[i] = (ovf_ff[i] || q_ff[i] > 32'h8000_0000) ? 32'sh8000_0000
                     : $signed(-q_ff[i]);
         else
            k_c[i] = (ovf_ff[i] || q_ff[i] > 32'h7FFF_FFFF) ? 32'sh7FFF_FFFF
                     : $signed(q_ff[i]);
      end
   end

   assign done = done_ff;
   assign k0   = k_c[0];
   assign k1   = k_c[1];

endmodule

// ----- hdl/pcf_dp.sv -----
// pcf_dp: state registers, two shared multipliers and the gain divider of the fusion block
// depends on pcf_pkg and pcf_div
module pcf_dp (
   input  logic                               clock,
   input  logic                               reset,
   input  pcf_pkg::cmd_type                   cmd,
   output logic                               div_done,
   input  logic signed [pcf_pkg::AngW-1:0]    tare_offset,
   input  logic [pcf_pkg::AlphaW-1:0]         blend_alpha,
   input  logic [pcf_pkg::NoiseW-1:0]         angle_noise,
   input  logic [pcf_pkg::NoiseW-1:0]         bias_noise,
   input  logic [pcf_pkg::NoiseW-1:0]         measure_noise,
   input  logic signed [pcf_pkg::AngW-1:0]    raw_angle,
   input  logic signed [pcf_pkg::RateW-1:0]   rate,
   input  logic [pcf_pkg::DtW-1:0]            step_time,
   output logic signed [pcf_pkg::AngW-1:0]    tared_angle,
   output logic signed [pcf_pkg::AngW-1:0]    blended_angle,
   output logic signed [pcf_pkg::AngW-1:0]    estimated_angle,
   output logic signed [pcf_pkg::RateW-1:0]   estimated_bias
);
   import pcf_pkg::*;

   logic signed [AngW-1:0]  tared_ff, tared_in;
   logic signed [RateW-1:0] rate_ff, rate_in;
   logic [DtW-1:0]          dt_ff, dt_in;
   logic signed [AngW-1:0]  blend_ff, blend_in;
   logic signed [AngW-1:0]  ang_ff, ang_in;
   logic signed [RateW-1:0] bias_ff, bias_in;
   logic signed [CovW-1:0]  aa_ff, aa_in, ab_ff, ab_in, ba_ff, ba_in, bb_ff, bb_in;
   logic signed [PredW-1:0] pred_ff, pred_in;
   logic signed [M1pW-1:0]  acc_ff, acc_in;
   logic signed [TbW-1:0]   tb_ff, tb_in;
   logic signed [YW-1:0]    y_ff, y_in;
   logic signed [M1pW-1:0]  p1_ff;
   logic signed [M2pW-1:0]  p2_ff;
   logic signed [AngW-1:0]  o_tared_ff, o_blend_ff, o_ang_ff;
   logic signed [RateW-1:0] o_bias_ff;

   logic [AlphaW-1:0]        alpha_c;
   logic signed [M1bW-1:0]   dt_s;
   logic signed [M1aW-1:0]   m1a;
   logic signed [M1bW-1:0]   m1b;
   logic signed [GainW-1:0]  m2a;
   logic signed [M2bW-1:0]   m2b;
   logic signed [GainW-1:0]  k0, k1;
   logic signed [SumW-1:0]   s_c;
   logic signed [63:0]       p1x, p2x, accx;

   assign alpha_c = (blend_alpha > AlphaOne) ? AlphaOne : blend_alpha;
   assign dt_s    = $signed({2'b00, dt_ff});
   assign p1x     = 64'(p1_ff);
   assign p2x     = 64'(p2_ff);
   assign accx    = 64'(acc_ff);
   assign s_c     = SumW'(aa_ff) + $signed({10'd0, measure_noise});

   // multiplier operand selection
   always_comb begin
      m1a = '0;
      m1b = '0;
      m2a = '0;
      m2b = '0;
      case (cmd.op)
         OP_PRED: begin m1a = M1aW'(rate_ff); m1b = dt_s; end
         OP_BA:   begin m1a = M1aW'(pred_ff); m1b = $signed({1'b0, alpha_c}); end
         OP_BT: begin
            m1a = M1aW'(tared_ff);
            m1b = $signed({1'b0, AlphaW'(AlphaOne - alpha_c)});
         end
         OP_ANG:  begin m1a = M1aW'(rate_ff) - M1aW'(bias_ff); m1b = dt_s; end
         OP_TB:   begin m1a = M1aW'(bb_ff); m1b = dt_s; end
         OP_AA: begin
            m1a = M1aW'(tb_ff) - M1aW'(ab_ff) - M1aW'(ba_ff)
                  + M1aW'($signed({1'b0, angle_noise}));
            m1b = dt_s;
         end
         OP_BB:    begin m1a = M1aW'($signed({1'b0, bias_noise})); m1b = dt_s; end
         OP_K0Y:   begin m2a = k0; m2b = M2bW'(y_ff); end
         OP_K1Y:   begin m2a = k1; m2b = M2bW'(y_ff); end
         OP_HI_BA: begin m2a = k1; m2b = M2bW'($signed(aa_ff[CovW-1:24])); end
         OP_LO_BA: begin m2a = k1; m2b = $signed({3'b000, aa_ff[23:0]}); end
         OP_HI_BB: begin m2a = k1; m2b = M2bW'($signed(ab_ff[CovW-1:24])); end
         OP_LO_BB: begin m2a = k1; m2b = $signed({3'b000, ab_ff[23:0]}); end
         OP_HI_AB: begin m2a = k0; m2b = M2bW'($signed(ab_ff[CovW-1:24])); end
         OP_LO_AB: begin m2a = k0; m2b = $signed({3'b000, ab_ff[23:0]}); end
         OP_HI_AA: begin m2a = k0; m2b = M2bW'($signed(aa_ff[CovW-1:24])); end
         OP_LO_AA: begin m2a = k0; m2b = $signed({3'b000, aa_ff[23:0]}); end
         default: begin m1a = '0; end
      endcase
   end

   // input capture, innovation and write back of the product registered in the previous cycle
   always_comb begin
      tared_in = tared_ff;
      rate_in  = rate_ff;
      dt_in    = dt_ff;
      blend_in = blend_ff;
      ang_in   = ang_ff;
      bias_in  = bias_ff;
      aa_in    = aa_ff;
      ab_in    = ab_ff;
      ba_in    = ba_ff;
      bb_in    = bb_ff;
      pred_in  = pred_ff;
      acc_in   = acc_ff;
      tb_in    = tb_ff;
      y_in     = y_ff;
      if (cmd.load_in) begin
         tared_in = AngW'(sat(64'(raw_angle) - 64'(tare_offset), AngMax));
         rate_in  = rate;
         dt_in    = step_time;
      end
      if (cmd.div_start)
         y_in = YW'(tared_ff) - YW'(ang_ff);
      if (cmd.phase) begin
         case (cmd.op)
            OP_PRED: pred_in  = PredW'(64'(blend_ff) + rnd(p1x, 16));
            OP_BA:   acc_in   = p1_ff;
            OP_BT:   blend_in = AngW'(sat(rnd(accx + p1x, 16), AngMax));
            OP_ANG:  ang_in   = AngW'(sat(64'(ang_ff) + rnd(p1x, 16), AngMax));
            OP_TB:   tb_in    = TbW'(rnd(p1x, 16));
            OP_AA: begin
               aa_in = CovW'(satcov(64'(aa_ff) + rnd(p1x, 16)));
               ab_in = CovW'(satcov(64'(ab_ff) - 64'(tb_ff)));
               ba_in = CovW'(satcov(64'(ba_ff) - 64'(tb_ff)));
            end
            OP_BB:   bb_in   = CovW'(satcov(64'(bb_ff) + rnd(p1x, 16)));
            OP_K0Y:  ang_in  = AngW'(sat(64'(ang_ff) + rnd(p2x, 24), AngMax));
            OP_K1Y:  bias_in = RateW'(sat(64'(bias_ff) + rnd(p2x, 24), BiasMax));
            OP_HI_BA, OP_HI_BB, OP_HI_AB, OP_HI_AA: acc_in = M1pW'(p2x);
            OP_LO_BA: ba_in = CovW'(satcov(64'(ba_ff) - (accx + rnd(p2x, 24))));
            OP_LO_BB: bb_in = CovW'(satcov(64'(bb_ff) - (accx + rnd(p2x, 24))));
            OP_LO_AB: ab_in = CovW'(satcov(64'(ab_ff) - (accx + rnd(p2x, 24))));
            OP_LO_AA: aa_in = CovW'(satcov(64'(aa_ff) - (accx + rnd(p2x, 24))));
            default: acc_in = acc_ff;
         endcase
      end
   end

   // filter state
   always_ff @(posedge clock) begin
      if (reset) begin
         blend_ff <= '0;
         ang_ff   <= '0;
         bias_ff  <= '0;
         aa_ff    <= $signed(OneQ24);
         ab_ff    <= '0;
         ba_ff    <= '0;
         bb_ff    <= $signed(OneQ24);
      end else begin
         blend_ff <= blend_in;
         ang_ff   <= ang_in;
         bias_ff  <= bias_in;
         aa_ff    <= aa_in;
         ab_ff    <= ab_in;
         ba_ff    <= ba_in;
         bb_ff    <= bb_in;
      end
   end

   // working registers and products
   always_ff @(posedge clock) begin
      tared_ff <= tared_in;
      rate_ff  <= rate_in;
      dt_ff    <= dt_in;
      pred_ff  <= pred_in;
      acc_ff   <= acc_in;
      tb_ff    <= tb_in;
      y_ff     <= y_in;
      if (!cmd.phase) begin
         p1_ff <= m1a * m1b;
         p2_ff <= m2a * m2b;
      end
      if (cmd.load_out) begin
         o_tared_ff <= tared_ff;
         o_blend_ff <= blend_ff;
         o_ang_ff   <= ang_ff;
         o_bias_ff  <= bias_ff;
      end
   end

   pcf_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .s     (s_c),
      .a0    (aa_ff),
      .a1    (ba_ff),
      .done  (div_done),
      .k0    (k0),
      .k1    (k1)
   );

   assign tared_angle     = o_tared_ff;
   assign blended_angle   = o_blend_ff;
   assign estimated_angle = o_ang_ff;
   assign estimated_bias  = o_bias_ff;

endmodule

// ----- hdl/pcf_ctrl.sv -----
// pcf_ctrl: sequencer of the fusion block, steps the micro-op list and the handshakes
// depends on pcf_pkg
module pcf_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic              div_done,
   output pcf_pkg::cmd_type  cmd
);
   import pcf_pkg::*;

   state_type       state_ff, state_in;
   logic [IdxW-1:0] idx_ff, idx_in;
   logic            phase_ff, phase_in;
   logic            rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      phase_in      = phase_ff;
      cmd.op        = OP_NONE;
      cmd.phase     = 1'b0;
      cmd.load_in   = 1'b0;
      cmd.div_start = 1'b0;
      cmd.load_out  = 1'b0;
      req_ready     = 1'b0;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_in = 1'b1;
               idx_in      = '0;
               phase_in    = 1'b0;
               state_in    = ST_PRE;
            end
         end
         ST_PRE, ST_POST: begin
            cmd.op    = op_at(idx_ff);
            cmd.phase = phase_ff;
            phase_in  = ~phase_ff;
            if (phase_ff) begin
               idx_in = idx_ff + 5'd1;
               if (state_ff == ST_PRE && idx_ff == PreLast) begin
                  cmd.div_start = 1'b1;
                  state_in      = ST_DIV;
               end else if (state_ff == ST_POST && idx_ff == PostLast) begin
                  state_in = ST_OUT;
               end
            end
         end
         ST_DIV: begin
            if (div_done)
               state_in = ST_POST;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         phase_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- hdl/pitch_complementary_kalman_fusion.sv -----
// pitch_complementary_kalman_fusion: top level with the register port
// depends on pcf_pkg, pcf_ctrl, pcf_dp (and pcf_div below it)
//
// Pitch fusion: each request beat carries an accelerometer pitch, a gyro rate
// and a time step (signed 25-bit Q9.16, signed 28-bit Q12.16, Q0.16). The tare
// offset is removed, then a complementary filter and a two-state Kalman filter
// (angle, gyro bias) are advanced. One response beat per request carries the
// tared pitch, the blended pitch, the Kalman pitch and the Kalman bias.
// From the accepted request to response valid the update runs seven
// multiply steps (multiply, then write back), the two-lane bit-serial gain
// divider, ten more multiply steps and the load of the output register.
// One update runs at a time; a new request is taken in the idle cycle after
// the previous update has moved into the output register.
// A stalled response holds in its register; the following update then waits
// at its end until that beat is taken.
// Reset loads the register defaults, clears the filter states and sets both
// covariance diagonals to one. Registers are written over the APB-style port
// at byte address 4*index; write them only while no update is in flight, as
// the block does not enforce this. pready is tied high.
module pitch_complementary_kalman_fusion (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [pcf_pkg::AngW-1:0]   req_raw_angle,
   input  logic signed [pcf_pkg::RateW-1:0]  req_rate,
   input  logic [pcf_pkg::DtW-1:0]           req_step_time,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [pcf_pkg::AngW-1:0]   rsp_tared_angle,
   output logic signed [pcf_pkg::AngW-1:0]   rsp_blended_angle,
   output logic signed [pcf_pkg::AngW-1:0]   rsp_estimated_angle,
   output logic signed [pcf_pkg::RateW-1:0]  rsp_estimated_bias,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [pcf_pkg::AddrW-1:0]         paddr,
   input  logic [31:0]                       pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready
);
   import pcf_pkg::*;

   logic signed [AngW-1:0] tare_ff;
   logic [AlphaW-1:0]      alpha_ff;
   logic [NoiseW-1:0]      anoise_ff, bnoise_ff, mnoise_ff;
   logic                   wr_c;
   logic [2:0]             reg_idx;
   cmd_type                cmd;
   logic                   div_done;

   assign pready  = 1'b1;
   assign reg_idx = paddr[AddrW-1:2];
   assign wr_c    = psel & penable & pwrite;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         tare_ff   <= -25'sd518390;
         alpha_ff  <= 17'd64225;
         anoise_ff <= 32'd16777;
         bnoise_ff <= 32'd50332;
         mnoise_ff <= 32'd503316;
      end else if (wr_c) begin
         case (reg_idx)
            REG_TARE:   tare_ff   <= $signed(pwdata[AngW-1:0]);
            REG_ALPHA:  alpha_ff  <= pwdata[AlphaW-1:0];
            REG_ANOISE: anoise_ff <= pwdata;
            REG_BNOISE: bnoise_ff <= pwdata;
            REG_MNOISE: mnoise_ff <= pwdata;
            default:    anoise_ff <= anoise_ff;
         endcase
      end
   end

   // register reads
   always_comb begin
      case (reg_idx)
         REG_TARE:   prdata = 32'(tare_ff);
         REG_ALPHA:  prdata = {15'd0, alpha_ff};
         REG_ANOISE: prdata = anoise_ff;
         REG_BNOISE: prdata = bnoise_ff;
         REG_MNOISE: prdata = mnoise_ff;
         default:    prdata = '0;
      endcase
   end

   pcf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .div_done  (div_done),
      .cmd       (cmd)
   );

   pcf_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .div_done        (div_done),
      .tare_offset     (tare_ff),
      .blend_alpha     (alpha_ff),
      .angle_noise     (anoise_ff),
      .bias_noise      (bnoise_ff),
      .measure_noise   (mnoise_ff),
      .raw_angle       (req_raw_angle),
      .rate            (req_rate),
      .step_time       (req_step_time),
      .tared_angle     (rsp_tared_angle),
      .blended_angle   (rsp_blended_angle),
      .estimated_angle (rsp_estimated_angle),
      .estimated_bias  (rsp_estimated_bias)
   );

endmodule
